[rtl/lbc_pkg.sv]
package lbc_pkg;

    // Sizes fixed by the item and register formats
    localparam int ACTION_W    = 3;
    localparam int INDEX_W     = 3;
    localparam int RATE_W      = 2;
    localparam int PINS_W      = 8;
    localparam int MODE_W      = 3;
    localparam int COUNT_W     = 4;
    localparam int PERIOD_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_MAX_LED_COUNT = 8;

    // Register reset values
    localparam logic                DEF_IDLE_LEVEL = 1'b0;
    localparam logic [COUNT_W-1:0]  DEF_LED_COUNT  = 4'd8;
    localparam logic [PERIOD_W-1:0] DEF_SLOW       = 16'd800;
    localparam logic [PERIOD_W-1:0] DEF_MEDIUM     = 16'd200;
    localparam logic [PERIOD_W-1:0] DEF_FAST       = 16'd100;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST       = 3'd4;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ON     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_OFF    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_BLINK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd5;

    // Blink rate codes
    localparam logic [RATE_W-1:0] RATE_SLOW   = 2'd0;
    localparam logic [RATE_W-1:0] RATE_MEDIUM = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 3'd0,
        MODE_ON     = 3'd1,
        MODE_SLOW   = 3'd2,
        MODE_MEDIUM = 3'd3,
        MODE_FAST   = 3'd4
    } lbc_mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } lbc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input item
        logic exec;   // apply the item and load the result register
    } lbc_cmd_t;

endpackage

[rtl/lbc_ctrl.sv]
module lbc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output lbc_pkg::lbc_cmd_t cmd
);
    import lbc_pkg::*;

    lbc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // wait for the result register to free up
                if (slot_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> in_stall)
        else $error("input taken while an item is in flight");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while held");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.exec))
        else $error("result raised without execution");

endmodule

[rtl/lbc_datapath.sv]
module lbc_datapath #(
    parameter int MAX_LED_COUNT = lbc_pkg::DEF_MAX_LED_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lbc_pkg::lbc_cmd_t                  cmd,
    input  logic [lbc_pkg::ACTION_W-1:0]       action,
    input  logic [lbc_pkg::INDEX_W-1:0]        led_index,
    input  logic [lbc_pkg::RATE_W-1:0]         blink_rate,
    input  logic                               cfg_we,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [lbc_pkg::PINS_W-1:0]         pin_levels,
    output logic [lbc_pkg::MODE_W-1:0]         mode_read,
    output logic                               lit_state,
    output logic                               index_error
);
    import lbc_pkg::*;

    localparam int PAD_W = (MAX_LED_COUNT > PINS_W) ? MAX_LED_COUNT : PINS_W;

    // Item captured at the input transfer
    logic [ACTION_W-1:0] action_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [RATE_W-1:0]   rate_reg;

    // Configuration
    logic                idle_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [PERIOD_W-1:0] slow_per_reg, medium_per_reg, fast_per_reg;

    // LED state and tick counters
    lbc_mode_t              mode_reg  [MAX_LED_COUNT];
    lbc_mode_t              mode_next [MAX_LED_COUNT];
    logic [MAX_LED_COUNT-1:0] lit_reg, lit_next;
    logic [PERIOD_W-1:0]    slow_cnt_reg, medium_cnt_reg, fast_cnt_reg;
    logic [PERIOD_W-1:0]    slow_cnt_next, medium_cnt_next, fast_cnt_next;

    // Result register
    logic [PINS_W-1:0] pins_reg;
    logic [MODE_W-1:0] mode_out_reg;
    logic              lit_out_reg, err_out_reg;

    logic              idx_ok, is_tick, is_cmd;
    logic              slow_hit, medium_hit, fast_hit;
    lbc_mode_t         rate_mode;
    logic [MODE_W-1:0] mode_out;
    logic              lit_out;
    logic              sel;
    logic [PAD_W-1:0]  lit_pad;
    logic [PINS_W-1:0] pins_next;

    // Counter fires when count+1 reaches the period; zero period acts as one
    function automatic logic period_hit(input logic [PERIOD_W-1:0] cnt,
                                        input logic [PERIOD_W-1:0] per);
        logic [PERIOD_W:0] nxt;
        logic [PERIOD_W:0] lim;
        nxt = {1'b0, cnt} + {{PERIOD_W{1'b0}}, 1'b1};
        lim = (per == '0) ? {{PERIOD_W{1'b0}}, 1'b1} : {1'b0, per};
        return nxt >= lim;
    endfunction

    assign idx_ok  = ({1'b0, index_reg} < count_reg) && (32'(index_reg) < MAX_LED_COUNT);
    assign is_tick = (action_reg == ACT_TICK);
    assign is_cmd  = (action_reg <= ACT_READ);

    assign slow_hit   = is_tick && period_hit(slow_cnt_reg, slow_per_reg);
    assign medium_hit = is_tick && period_hit(medium_cnt_reg, medium_per_reg);
    assign fast_hit   = is_tick && period_hit(fast_cnt_reg, fast_per_reg);

    always_comb
    begin
        slow_cnt_next   = slow_cnt_reg;
        medium_cnt_next = medium_cnt_reg;
        fast_cnt_next   = fast_cnt_reg;
        if (is_tick)
        begin
            slow_cnt_next   = slow_hit   ? '0 : slow_cnt_reg + PERIOD_W'(1);
            medium_cnt_next = medium_hit ? '0 : medium_cnt_reg + PERIOD_W'(1);
            fast_cnt_next   = fast_hit   ? '0 : fast_cnt_reg + PERIOD_W'(1);
        end
    end

    always_comb
    begin
        case (rate_reg)
            RATE_SLOW:   rate_mode = MODE_SLOW;
            RATE_MEDIUM: rate_mode = MODE_MEDIUM;
            default:     rate_mode = MODE_FAST;
        endcase
    end

    // Per-LED next state, one lane per LED
    always_comb
    begin
        mode_out = MODE_OFF;
        lit_out  = 1'b0;
        sel      = 1'b0;
        for (int i = 0; i < MAX_LED_COUNT; i++)
        begin
            mode_next[i] = mode_reg[i];
            lit_next[i]  = lit_reg[i];
            if (is_tick && (i < int'(count_reg)))
            begin
                if ((mode_reg[i] == MODE_SLOW && slow_hit) ||
                    (mode_reg[i] == MODE_MEDIUM && medium_hit) ||
                    (mode_reg[i] == MODE_FAST && fast_hit))
                begin
                    lit_next[i] = ~lit_reg[i];
                end
            end
            sel = is_cmd && idx_ok && (32'(index_reg) == i);
            if (sel)
            begin
                case (action_reg)
                    ACT_ON:
                    begin
                        mode_next[i] = MODE_ON;
                        lit_next[i]  = 1'b1;
                    end
                    ACT_OFF:
                    begin
                        mode_next[i] = MODE_OFF;
                        lit_next[i]  = 1'b0;
                    end
                    ACT_BLINK:
                    begin
                        mode_next[i] = rate_mode;
                    end
                    ACT_TOGGLE:
                    begin
                        lit_next[i]  = ~lit_reg[i];
                        mode_next[i] = lit_reg[i] ? MODE_OFF : MODE_ON;
                    end
                    default:
                    begin
                    end
                endcase
                mode_out = mode_next[i];
                lit_out  = lit_next[i];
            end
        end
    end

    // Pins past the LED storage show the idle level
    assign lit_pad   = PAD_W'(lit_next);
    assign pins_next = lit_pad[PINS_W-1:0] ^ {PINS_W{idle_reg}};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            index_reg  <= led_index;
            rate_reg   <= blink_rate;
        end
        if (cmd.exec)
        begin
            pins_reg     <= pins_next;
            mode_out_reg <= mode_out;
            lit_out_reg  <= lit_out;
            err_out_reg  <= is_cmd && !idx_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg       <= DEF_IDLE_LEVEL;
            count_reg      <= DEF_LED_COUNT;
            slow_per_reg   <= DEF_SLOW;
            medium_per_reg <= DEF_MEDIUM;
            fast_per_reg   <= DEF_FAST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IDLE_LEVEL: idle_reg       <= cfg_data[0];
                REG_LED_COUNT:  count_reg      <= cfg_data[COUNT_W-1:0];
                REG_SLOW:       slow_per_reg   <= cfg_data[PERIOD_W-1:0];
                REG_MEDIUM:     medium_per_reg <= cfg_data[PERIOD_W-1:0];
                REG_FAST:       fast_per_reg   <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LED_COUNT; i++)
            begin
                mode_reg[i] <= MODE_OFF;
            end
            lit_reg        <= '0;
            slow_cnt_reg   <= '0;
            medium_cnt_reg <= '0;
            fast_cnt_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            for (int i = 0; i < MAX_LED_COUNT; i++)
            begin
                mode_reg[i] <= mode_next[i];
            end
            lit_reg        <= lit_next;
            slow_cnt_reg   <= slow_cnt_next;
            medium_cnt_reg <= medium_cnt_next;
            fast_cnt_reg   <= fast_cnt_next;
        end
    end

    assign pin_levels  = pins_reg;
    assign mode_read   = mode_out_reg;
    assign lit_state   = lit_out_reg;
    assign index_error = err_out_reg;

endmodule

[rtl/multi_led_blink_controller.sv]
// Channel   Handshake              Payload
// input     in_valid / in_stall    action, led_index, blink_rate
// result    out_valid / out_stall  pin_levels, mode_read, lit_state, index_error
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item is first captured from the input transfer, then executed in the
// shared LED datapath that updates all lanes and loads the result register.
// A held result (out_stall) delays the execute cycle of the next item only.
// Reset: all LEDs off and dark, tick counters zero, registers at defaults.
// cfg_ready is always high; writes are expected only while the block is idle.
module multi_led_blink_controller #(
    parameter int MAX_LED_COUNT = lbc_pkg::DEF_MAX_LED_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lbc_pkg::ACTION_W-1:0]       action,
    input  logic [lbc_pkg::INDEX_W-1:0]        led_index,
    input  logic [lbc_pkg::RATE_W-1:0]         blink_rate,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lbc_pkg::PINS_W-1:0]         pin_levels,
    output logic [lbc_pkg::MODE_W-1:0]         mode_read,
    output logic                               lit_state,
    output logic                               index_error,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lbc_pkg::*;

    lbc_cmd_t cmd;
    logic     cfg_we;

    // Register writes never wait
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Sequencer: input capture, execute, result register ownership
    lbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // LED lanes, tick counters, config and result registers
    lbc_datapath #(
        .MAX_LED_COUNT (MAX_LED_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .led_index   (led_index),
        .blink_rate  (blink_rate),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pin_levels  (pin_levels),
        .mode_read   (mode_read),
        .lit_state   (lit_state),
        .index_error (index_error)
    );

endmodule
